// File: src/gvt_pkg.sv
// shared types, constants and helpers for the grid voxel traversal unit
package gvt_pkg;

    // coordinate and register widths
    localparam int COORD_W = 6;
    localparam int POS_W   = COORD_W + 2;
    localparam int ERR_W   = 14;

    // largest grid size honored in either dimension
    localparam logic [COORD_W-1:0] GRID_MAX = 6'd32;

    // most results given for one segment
    localparam logic [COORD_W-1:0] RES_LIMIT = 6'd63;

    // configuration register indexes
    localparam logic [0:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_GRID_HEIGHT = 1'b1;

    // sequencer states
    typedef enum logic {
        S_IDLE,
        S_WALK
    } gvt_state_t;

    // true when a two's complement position lies in [0, lim)
    function automatic logic in_range(input logic [POS_W-1:0] pos,
                                      input logic [COORD_W-1:0] lim);
        in_range = !pos[POS_W-1] && (pos[POS_W-2:0] < {1'b0, lim});
    endfunction

endpackage

// File: src/grid_voxel_traversal_unit.sv
// grid voxel traversal unit: walks a segment cell by cell with one shared error adder
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------------
//   cfg      | cfg_we                | cfg_index, cfg_wdata
//   in       | in_valid / in_ready   | begin_x, begin_y, end_x, end_y
//   out      | out_valid / out_ready | cell_x, cell_y, valid_res, reached_end, last
//
// a segment is loaded while idle, then the walk gives one result beat per cycle unless the
// output register is stalled; the error adder is stepped once per cell
// reset clears the sequencer and the output valid flag and sets both grid sizes to 32
// a stalled output register holds the walk in place; in_ready rises in the same cycle that the
// final beat of a segment enters the output register, while that beat may still wait
module grid_voxel_traversal_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [gvt_pkg::COORD_W-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [gvt_pkg::COORD_W-1:0] begin_x,
    input  logic [gvt_pkg::COORD_W-1:0] begin_y,
    input  logic [gvt_pkg::COORD_W-1:0] end_x,
    input  logic [gvt_pkg::COORD_W-1:0] end_y,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gvt_pkg::COORD_W-1:0] cell_x,
    output logic [gvt_pkg::COORD_W-1:0] cell_y,
    output logic                       valid_res,
    output logic                       reached_end,
    output logic                       last
);
    import gvt_pkg::*;

    gvt_state_t state_reg, state_next;

    logic [COORD_W-1:0] gw_reg, gh_reg;
    logic [COORD_W-1:0] gw_eff, gh_eff;

    logic [POS_W-1:0]   cur_x_reg, cur_y_reg, stop_x_reg, stop_y_reg;
    logic [ERR_W-1:0]   err_reg;
    logic [COORD_W-1:0] adx_reg, ady_reg;
    logic               neg_x_reg, neg_y_reg;
    logic [COORD_W-1:0] cnt_reg;

    logic               out_valid_reg;
    logic [COORD_W-1:0] cell_x_reg, cell_y_reg;
    logic               valid_res_reg, reached_end_reg, last_reg;

    logic               in_fire, out_free;
    logic               in_grid_cur, at_stop, step_x;
    logic [POS_W-1:0]   nxt_x, nxt_y;
    logic [ERR_W-1:0]   err_operand, err_sum;
    logic               look_last;
    logic               emit, emit_valid, emit_end, emit_last, advance;

    logic               neg_x_in, neg_y_in, pos_x_in, pos_y_in;
    logic [COORD_W-1:0] adx_in, ady_in;

    // effective grid size after clamping
    assign gw_eff = (gw_reg > GRID_MAX) ? GRID_MAX : gw_reg;
    assign gh_eff = (gh_reg > GRID_MAX) ? GRID_MAX : gh_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // segment setup from the input beat
    assign neg_x_in = end_x < begin_x;
    assign neg_y_in = end_y < begin_y;
    assign pos_x_in = end_x > begin_x;
    assign pos_y_in = end_y > begin_y;
    assign adx_in   = neg_x_in ? (begin_x - end_x) : (end_x - begin_x);
    assign ady_in   = neg_y_in ? (begin_y - end_y) : (end_y - begin_y);

    // current cell checks
    assign in_grid_cur = in_range(cur_x_reg, gw_eff) && in_range(cur_y_reg, gh_eff);
    assign at_stop     = (cur_x_reg == stop_x_reg) && (cur_y_reg == stop_y_reg);
    assign step_x      = err_reg[ERR_W-1];

    // shared error adder: add |dy| on an x step, subtract |dx| on a y step
    assign err_operand = step_x ? {{(ERR_W-COORD_W){1'b0}}, ady_reg}
                                : (~{{(ERR_W-COORD_W){1'b0}}, adx_reg} + 1'b1);
    assign err_sum     = err_reg + err_operand;

    // next cell position
    always_comb
    begin
        nxt_x = cur_x_reg;
        nxt_y = cur_y_reg;
        if (step_x)
        begin
            nxt_x = neg_x_reg ? (cur_x_reg - 1'b1) : (cur_x_reg + 1'b1);
        end
        else
        begin
            nxt_y = neg_y_reg ? (cur_y_reg - 1'b1) : (cur_y_reg + 1'b1);
        end
    end

    // a normal cell is final when the limit is hit or the walk leaves the grid
    assign look_last = (cnt_reg == RES_LIMIT - 1'b1)
        || (!(in_range(nxt_x, gw_eff) && in_range(nxt_y, gh_eff))
            && !((nxt_x == stop_x_reg) && (nxt_y == stop_y_reg)));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (emit && emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        emit       = 1'b0;
        emit_valid = 1'b0;
        emit_end   = 1'b0;
        emit_last  = 1'b0;
        advance    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                emit = 1'b0;
            end
            S_WALK:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (in_grid_cur && !at_stop)
                    begin
                        emit_valid = 1'b1;
                        emit_last  = look_last;
                        advance    = 1'b1;
                    end
                    else if (at_stop)
                    begin
                        emit_valid = 1'b1;
                        emit_end   = 1'b1;
                        emit_last  = 1'b1;
                    end
                    else
                    begin
                        // empty path
                        emit_last = 1'b1;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            gw_reg        <= 6'd32;
            gh_reg        <= 6'd32;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GRID_WIDTH:  gw_reg <= cfg_wdata;
                    CFG_GRID_HEIGHT: gh_reg <= cfg_wdata;
                    default:         gw_reg <= gw_reg;
                endcase
            end
            if (in_fire)
            begin
                cnt_reg <= '0;
            end
            else if (advance)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // walk datapath and output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            neg_x_reg  <= neg_x_in;
            neg_y_reg  <= neg_y_in;
            adx_reg    <= adx_in;
            ady_reg    <= ady_in;
            cur_x_reg  <= {2'b00, begin_x} - {{(POS_W-1){1'b0}}, neg_x_in};
            cur_y_reg  <= {2'b00, begin_y} - {{(POS_W-1){1'b0}}, neg_y_in};
            stop_x_reg <= {2'b00, end_x} - {{(POS_W-1){1'b0}}, pos_x_in};
            stop_y_reg <= {2'b00, end_y} - {{(POS_W-1){1'b0}}, pos_y_in};
            err_reg    <= {{(ERR_W-COORD_W){1'b0}}, ady_in}
                        - {{(ERR_W-COORD_W){1'b0}}, adx_in};
        end
        else if (advance)
        begin
            cur_x_reg <= nxt_x;
            cur_y_reg <= nxt_y;
            err_reg   <= err_sum;
        end
        if (emit)
        begin
            cell_x_reg      <= emit_valid ? cur_x_reg[COORD_W-1:0] : '0;
            cell_y_reg      <= emit_valid ? cur_y_reg[COORD_W-1:0] : '0;
            valid_res_reg   <= emit_valid;
            reached_end_reg <= emit_end;
            last_reg        <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cell_x      = cell_x_reg;
    assign cell_y      = cell_y_reg;
    assign valid_res   = valid_res_reg;
    assign reached_end = reached_end_reg;
    assign last        = last_reg;

    // the walk never runs past the result limit
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> cnt_reg < RES_LIMIT)
        else $error("walk count past result limit");

    // an accepted segment always starts a walk with the input side closed
    a_start_walk: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_WALK && !in_ready)
        else $error("segment accepted without starting a walk");

    // end cell and empty path beats always close the segment
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (reached_end_reg || !valid_res_reg) |-> last_reg)
        else $error("end or empty beat not marked last");

    // a cell that is not the end cell lies inside the grid
    a_cell_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && valid_res_reg && !reached_end_reg
        |-> cell_x_reg < gw_eff && cell_y_reg < gh_eff)
        else $error("crossed cell outside grid");

endmodule

// File: tb/sv/grid_voxel_traversal_unit_tb.sv
// self-checking testbench for the grid voxel traversal unit: directed, then random segments
module grid_voxel_traversal_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import gvt_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 70;
    localparam int NUM_DIRECTED = 22;
    localparam int NUM_PHASES   = 8;
    localparam int FIRST_RANDOM = 40;
    localparam int PHASE_ITEMS  = 26;
    localparam int PRINT_CAP    = 100;

    // one result beat as it leaves the block
    typedef struct packed {
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               valid_res;
        logic               reached_end;
        logic               last;
    } cell_beat_t;

    // directed segment, with a typed single result where it is obvious
    typedef struct packed {
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic               known;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic               tv;
        logic               te;
    } seg_row_t;

    // directed segments, all walked with the reset grid of 32 x 32
    localparam seg_row_t DIR_ROWS [NUM_DIRECTED] = '{
        '{6'd5,  6'd5,  6'd5,  6'd5,  1'b1, 6'd5,  6'd5,  1'b1, 1'b1}, // begin equals end
        '{6'd0,  6'd0,  6'd0,  6'd0,  1'b1, 6'd0,  6'd0,  1'b1, 1'b1}, // origin point
        '{6'd63, 6'd63, 6'd63, 6'd63, 1'b1, 6'd63, 6'd63, 1'b1, 1'b1}, // end cell off the grid
        '{6'd40, 6'd3,  6'd50, 6'd3,  1'b1, 6'd0,  6'd0,  1'b0, 1'b0}, // starts off the grid
        '{6'd0,  6'd0,  6'd1,  6'd0,  1'b1, 6'd0,  6'd0,  1'b1, 1'b1}, // one cell forward
        '{6'd32, 6'd32, 6'd31, 6'd31, 1'b1, 6'd31, 6'd31, 1'b1, 1'b1}, // one cell backward
        '{6'd63, 6'd63, 6'd0,  6'd0,  1'b1, 6'd0,  6'd0,  1'b0, 1'b0}, // far corner inward
        '{6'd63, 6'd0,  6'd0,  6'd63, 1'b1, 6'd0,  6'd0,  1'b0, 1'b0}, // off grid, mixed signs
        '{6'd0,  6'd63, 6'd63, 6'd0,  1'b1, 6'd0,  6'd0,  1'b0, 1'b0}, // off grid, mixed signs
        '{6'd0,  6'd0,  6'd32, 6'd32, 1'b0, 6'd0,  6'd0,  1'b0, 1'b0}, // full diagonal
        '{6'd32, 6'd32, 6'd0,  6'd0,  1'b0, 6'd0,  6'd0,  1'b0, 1'b0}, // full diagonal back
        '{6'd0,  6'd0,  6'd63, 6'd63, 1'b0, 6'd0,  6'd0,  1'b0, 1'b0}, // hits the result cap
        '{6'd0,  6'd0,  6'd32, 6'd0,  1'b0, 6'd0,  6'd0,  1'b0, 1'b0}, // horizontal
        '{6'd0,  6'd32, 6'd0,  6'd0,  1'b0, 6'd0,  6'd0,  1'b0, 1'b0}, // vertical down
        '{6'd0,  6'd0,  6'd32, 6'd1,  1'b0, 6'd0,  6'd0,  1'b0, 1'b0}, // shallow
        '{6'd0,  6'd0,  6'd1,  6'd32, 1'b0, 6'd0,  6'd0,  1'b0, 1'b0}, // steep
        '{6'd0,  6'd0,  6'd2,  6'd2,  1'b0, 6'd0,  6'd0,  1'b0, 1'b0}, // ties step y
        '{6'd10, 6'd20, 6'd4,  6'd5,  1'b0, 6'd0,  6'd0,  1'b0, 1'b0}, // both negative
        '{6'd31, 6'd0,  6'd0,  6'd31, 1'b0, 6'd0,  6'd0,  1'b0, 1'b0}, // mixed signs
        '{6'd0,  6'd0,  6'd40, 6'd10, 1'b0, 6'd0,  6'd0,  1'b0, 1'b0}, // leaves through x
        '{6'd32, 6'd0,  6'd0,  6'd0,  1'b0, 6'd0,  6'd0,  1'b0, 1'b0}, // horizontal back
        '{6'd42, 6'd21, 6'd21, 6'd42, 1'b0, 6'd0,  6'd0,  1'b0, 1'b0}  // alternating bits
    };

    // grid settings per phase, the last one is drawn at random
    localparam logic [COORD_W-1:0] PHASE_W [NUM_PHASES] =
        '{6'd1, 6'd32, 6'd1,  6'd0,  6'd63, 6'd33, 6'd17, 6'd0};
    localparam logic [COORD_W-1:0] PHASE_H [NUM_PHASES] =
        '{6'd1, 6'd1,  6'd32, 6'd17, 6'd63, 6'd8,  6'd25, 6'd0};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [COORD_W-1:0] cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [COORD_W-1:0] begin_x;
    logic [COORD_W-1:0] begin_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic               out_valid;
    logic               out_ready;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               valid_res;
    logic               reached_end;
    logic               last;

    // mirror of the grid size registers
    logic [COORD_W-1:0] grid_w;
    logic [COORD_W-1:0] grid_h;

    cell_beat_t pending_cells [$];
    logic       quiet_tail;
    int         fail_count     = 0;
    int         cycle_count    = 0;
    int         segments_sent  = 0;
    int         cells_checked  = 0;
    int         settings_used  = 1;

    grid_voxel_traversal_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .begin_x     (begin_x),
        .begin_y     (begin_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .valid_res   (valid_res),
        .reached_end (reached_end),
        .last        (last)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still due",
                     cycle_count, pending_cells.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one line per mismatch, printed for the first PRINT_CAP only
    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        if (fail_count < PRINT_CAP)
            $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // walk the segment across the mirrored grid and queue the cells it crosses
    function automatic void trace_segment(input logic [COORD_W-1:0] bx,
                                          input logic [COORD_W-1:0] by,
                                          input logic [COORD_W-1:0] ex,
                                          input logic [COORD_W-1:0] ey);
        int dx, dy, adx, ady, stx, sty, gw, gh;
        int px, py, qx, qy, nx, ny, n, k;
        cell_beat_t path [64];
        dx  = int'(ex) - int'(bx);
        dy  = int'(ey) - int'(by);
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        stx = dx < 0 ? -1 : 1;
        sty = dy < 0 ? -1 : 1;
        gw  = int'(grid_w) > int'(GRID_MAX) ? int'(GRID_MAX) : int'(grid_w);
        gh  = int'(grid_h) > int'(GRID_MAX) ? int'(GRID_MAX) : int'(grid_h);
        // start cell by direction, end cell by reversed direction
        px  = dx < 0 ? int'(bx) - 1 : int'(bx);
        py  = dy < 0 ? int'(by) - 1 : int'(by);
        qx  = dx > 0 ? int'(ex) - 1 : int'(ex);
        qy  = dy > 0 ? int'(ey) - 1 : int'(ey);
        nx  = 0;
        ny  = 0;
        n   = 0;
        while (n < int'(RES_LIMIT) && px >= 0 && px < gw && py >= 0 && py < gh &&
               (px != qx || py != qy))
        begin
            path[n] = {px[COORD_W-1:0], py[COORD_W-1:0], 1'b1, 1'b0, 1'b0};
            n++;
            // exact compare, ties step y
            if ((nx + 1) * ady < (ny + 1) * adx)
            begin
                nx++;
                px += stx;
            end
            else
            begin
                ny++;
                py += sty;
            end
        end
        // end cell is given even off the grid
        if (n < int'(RES_LIMIT) && px == qx && py == qy)
        begin
            path[n] = {px[COORD_W-1:0], py[COORD_W-1:0], 1'b1, 1'b1, 1'b0};
            n++;
        end
        // empty path marker
        if (n == 0)
        begin
            path[0] = '0;
            n = 1;
        end
        path[n-1].last = 1'b1;
        for (k = 0; k < n; k++)
            pending_cells.insert(pending_cells.size(), path[k]);
    endfunction

    // write both grid size registers
    task automatic set_grid(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GRID_WIDTH;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_index <= CFG_GRID_HEIGHT;
        cfg_wdata <= h;
        @(negedge clk);
        cfg_we    <= 1'b0;
        grid_w = w;
        grid_h = h;
        settings_used++;
    endtask

    // drop valid and wait until every queued cell has come out
    task automatic drain_cells();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
    endtask

    // offer one segment beat, optionally after a random gap
    task automatic send_segment(input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by,
                                input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                                input logic use_typed, input cell_beat_t typed_beat);
        if (!quiet_tail && $urandom_range(0, 2) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        begin_x  <= bx;
        begin_y  <= by;
        end_x    <= ex;
        end_y    <= ey;
        do
            @(posedge clk);
        while (!in_ready);
        if (use_typed)
            pending_cells.insert(pending_cells.size(), typed_beat);
        else
            trace_segment(bx, by, ex, ey);
        segments_sent++;
    endtask

    // random segment, mostly inside the current grid
    task automatic pick_segment(output logic [COORD_W-1:0] bx, output logic [COORD_W-1:0] by,
                                output logic [COORD_W-1:0] ex, output logic [COORD_W-1:0] ey);
        int limx, limy, mode, t;
        limx = (grid_w == 0 || int'(grid_w) > int'(GRID_MAX)) ? int'(GRID_MAX) : int'(grid_w);
        limy = (grid_h == 0 || int'(grid_h) > int'(GRID_MAX)) ? int'(GRID_MAX) : int'(grid_h);
        mode = $urandom_range(0, 9);
        if (mode <= 5)
        begin
            bx = COORD_W'($urandom_range(0, limx));
            by = COORD_W'($urandom_range(0, limy));
            ex = COORD_W'($urandom_range(0, limx));
            ey = COORD_W'($urandom_range(0, limy));
        end
        else if (mode <= 7)
        begin
            // short segment
            bx = COORD_W'($urandom_range(0, 32));
            by = COORD_W'($urandom_range(0, 32));
            t  = int'(bx) + int'($urandom_range(0, 6)) - 3;
            ex = t < 0 ? 6'd0 : t[COORD_W-1:0];
            t  = int'(by) + int'($urandom_range(0, 6)) - 3;
            ey = t < 0 ? 6'd0 : t[COORD_W-1:0];
        end
        else if (mode == 8)
        begin
            // single point
            bx = COORD_W'($urandom_range(0, 63));
            by = COORD_W'($urandom_range(0, 63));
            ex = bx;
            ey = by;
        end
        else
        begin
            bx = COORD_W'($urandom_range(0, 63));
            by = COORD_W'($urandom_range(0, 63));
            ex = COORD_W'($urandom_range(0, 63));
            ey = COORD_W'($urandom_range(0, 63));
        end
    endtask

    // receiver with stall bursts
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge clk);
            end
        end
    end

    // compare each result beat with the oldest expected cell
    always @(posedge clk)
    begin
        cell_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cells.size() == 0)
                flag_mismatch("unexpected beat", {cell_x, 2'b00}, 8'h00);
            else
            begin
                want = pending_cells.pop_front();
                cells_checked++;
                if (cell_x !== want.cell_x)
                    flag_mismatch("cell_x", cell_x, want.cell_x);
                if (cell_y !== want.cell_y)
                    flag_mismatch("cell_y", cell_y, want.cell_y);
                if (valid_res !== want.valid_res)
                    flag_mismatch("valid_res", valid_res, want.valid_res);
                if (reached_end !== want.reached_end)
                    flag_mismatch("reached_end", reached_end, want.reached_end);
                if (last !== want.last)
                    flag_mismatch("last", last, want.last);
            end
        end
    end

    // stimulus
    initial
    begin
        int i, p, j;
        logic [COORD_W-1:0] bx, by, ex, ey, w, h;
        cell_beat_t typed_beat;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_GRID_WIDTH;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        begin_x    = '0;
        begin_y    = '0;
        end_x      = '0;
        end_y      = '0;
        quiet_tail = 1'b0;
        grid_w     = GRID_MAX;
        grid_h     = GRID_MAX;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed segments on the reset grid
        for (i = 0; i < NUM_DIRECTED; i++)
        begin
            typed_beat = {DIR_ROWS[i].tx, DIR_ROWS[i].ty, DIR_ROWS[i].tv, DIR_ROWS[i].te, 1'b1};
            send_segment(DIR_ROWS[i].bx, DIR_ROWS[i].by, DIR_ROWS[i].ex, DIR_ROWS[i].ey,
                         DIR_ROWS[i].known, typed_beat);
        end

        // random segments on the reset grid, with one full drain midway
        for (j = 0; j < FIRST_RANDOM; j++)
        begin
            if (j == FIRST_RANDOM / 2)
                drain_cells();
            pick_segment(bx, by, ex, ey);
            send_segment(bx, by, ex, ey, 1'b0, '0);
        end

        // phases over grid settings, last one without idling
        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain_cells();
            w = PHASE_W[p];
            h = PHASE_H[p];
            if (p == NUM_PHASES - 1)
            begin
                w = COORD_W'($urandom_range(0, 63));
                h = COORD_W'($urandom_range(0, 63));
                quiet_tail = 1'b1;
            end
            set_grid(w, h);
            for (j = 0; j < PHASE_ITEMS; j++)
            begin
                pick_segment(bx, by, ex, ey);
                send_segment(bx, by, ex, ey, 1'b0, '0);
            end
        end

        drain_cells();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("walked %0d segments under %0d grid settings (zero, one and oversized sizes)",
                 segments_sent, settings_used);
        $display("checked %0d result beats, %0d mismatches", cells_checked, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
